// File: rtl/core/mpsm_pkg.sv
// Shared constants, command codes and the control bundle for the signature matcher.
`timescale 1ns / 1ps
package mpsm_pkg;

  localparam int DEF_NUM_ENTRIES = 8;
  localparam int DEF_MAX_LEN     = 64;

  localparam int CMD_W   = 2;
  localparam int ENTRY_W = 3;
  localparam int POS_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int TPL_BYTES = 64;

  localparam logic [CMD_W-1:0] CMD_LOAD_BYTE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_LEN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PACKET    = 2'd2;

  typedef struct packed {
    // load side, valid in the accept cycle
    logic               ld_byte;
    logic               ld_len;
    logic               ld_kind;
    logic [ENTRY_W-1:0] ld_entry;
    logic [POS_W-1:0]   ld_pos;
    logic [BYTE_W-1:0]  ld_data;
    logic               ld_care;
    logic [LEN_W-1:0]   ld_len_val;
    // template read address for the byte being accepted
    logic               rd_kind;
    logic [POS_W-1:0]   rd_pos;
    // compare stage, in the cycle after accept
    logic               cmp_valid;
    logic               cmp_last;
    logic               cmp_kind;
    logic               cmp_pos_ok;
    logic [POS_W-1:0]   cmp_pos;
    logic [BYTE_W-1:0]  cmp_byte;
    logic [LEN_W-1:0]   cmp_cnt;
    // priority token moves one cell per cycle
    logic               resolve;
  } cell_ctl_t;

endpackage

// File: rtl/core/mpsm_cell.sv
// One signature entry: template memory, lengths, match bit and priority hop.
`timescale 1ns / 1ps
module mpsm_cell
  import mpsm_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int CELL_IDX    = 0,
  localparam int EW         = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctl_t            ctl,
  input  logic                 fnd_in,
  input  logic [EW-1:0]        idx_in,
  output logic                 fnd_out,
  output logic [EW-1:0]        idx_out
);

  localparam logic [5:0]    MY_ENTRY = 6'(CELL_IDX);
  localparam logic [EW-1:0] MY_IDX   = EW'(CELL_IDX);

  // {care, byte} per template position, both kinds
  logic [BYTE_W:0] mem [0:2*TPL_BYTES-1];
  logic [BYTE_W:0] rd_q;
  logic [LEN_W-1:0] len_r [0:1];
  logic sm;
  logic hit;

  logic             sel;
  logic [LEN_W-1:0] len_k;
  logic             mism;

  assign sel   = ({3'b000, ctl.ld_entry} == MY_ENTRY);
  assign len_k = len_r[ctl.cmp_kind];
  assign mism  = ctl.cmp_pos_ok && rd_q[BYTE_W] && ({1'b0, ctl.cmp_pos} < len_k)
                 && (rd_q[BYTE_W-1:0] != ctl.cmp_byte);

  always_ff @(posedge clk) begin
    if (ctl.ld_byte && sel) begin
      mem[{ctl.ld_kind, ctl.ld_pos}] <= {ctl.ld_care, ctl.ld_data};
    end
    rd_q <= mem[{ctl.rd_kind, ctl.rd_pos}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_r[0] <= '0;
      len_r[1] <= '0;
      sm       <= 1'b1;
      hit      <= 1'b0;
      fnd_out  <= 1'b0;
      idx_out  <= '0;
    end else begin
      if (ctl.ld_len && sel) begin
        len_r[ctl.ld_kind] <= ctl.ld_len_val;
      end
      if (ctl.cmp_valid) begin
        if (ctl.cmp_last) begin
          hit <= sm && !mism && (len_k != '0) && (ctl.cmp_cnt >= len_k);
          sm  <= 1'b1;
        end else if (mism) begin
          sm <= 1'b0;
        end
      end
      if (ctl.resolve) begin
        fnd_out <= fnd_in || hit;
        idx_out <= fnd_in ? idx_in : MY_IDX;
      end
    end
  end

endmodule

// File: rtl/core/mpsm_ctrl.sv
// Command decode, byte counter, compare-stage registers and result sequencer.
`timescale 1ns / 1ps
module mpsm_ctrl
  import mpsm_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int MAX_LEN     = DEF_MAX_LEN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CMD_W-1:0]   cmd,
  input  logic               kind,
  input  logic [ENTRY_W-1:0] entry,
  input  logic [POS_W-1:0]   position,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               care,
  input  logic [LEN_W-1:0]   length,
  input  logic               last_byte,
  output logic               busy,
  output logic               done,
  output cell_ctl_t          ctl
);

  localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int XW = (CW > LEN_W) ? CW : LEN_W;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_EVAL    = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [EW-1:0] rcnt;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_inc;

  logic [XW-1:0] cnt_x;
  logic [XW-1:0] inc_x;
  logic          acc;
  logic          pkt_acc;

  logic          cmp_valid;
  logic          cmp_last;
  logic          cmp_kind;
  logic          cmp_pos_ok;
  logic [POS_W-1:0]  cmp_pos;
  logic [BYTE_W-1:0] cmp_byte;
  logic [LEN_W-1:0]  cmp_cnt;

  assign busy    = (state != ST_IDLE);
  assign done    = (state == ST_DONE);
  assign acc     = start && !busy;
  assign pkt_acc = acc && (cmd == CMD_PACKET);

  assign cnt_inc = (cnt < CW'(MAX_LEN)) ? cnt + 1'b1 : cnt;
  assign cnt_x   = XW'(cnt);
  assign inc_x   = XW'(cnt_inc);

  always_comb begin
    ctl            = '0;
    ctl.ld_byte    = acc && (cmd == CMD_LOAD_BYTE);
    ctl.ld_len     = acc && (cmd == CMD_SET_LEN);
    ctl.ld_kind    = kind;
    ctl.ld_entry   = entry;
    ctl.ld_pos     = position;
    ctl.ld_data    = data_byte;
    ctl.ld_care    = care;
    ctl.ld_len_val = length;
    ctl.rd_kind    = kind;
    ctl.rd_pos     = cnt_x[POS_W-1:0];
    ctl.cmp_valid  = cmp_valid;
    ctl.cmp_last   = cmp_last;
    ctl.cmp_kind   = cmp_kind;
    ctl.cmp_pos_ok = cmp_pos_ok;
    ctl.cmp_pos    = cmp_pos;
    ctl.cmp_byte   = cmp_byte;
    ctl.cmp_cnt    = cmp_cnt;
    ctl.resolve    = (state == ST_RESOLVE);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (pkt_acc && last_byte) state_next = ST_EVAL;
      ST_EVAL:    state_next = ST_RESOLVE;
      ST_RESOLVE: if (rcnt == EW'(NUM_ENTRIES - 1)) state_next = ST_DONE;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rcnt      <= '0;
      cnt       <= '0;
      cmp_valid <= 1'b0;
      cmp_last  <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= pkt_acc;
      cmp_last  <= pkt_acc && last_byte;
      if (state == ST_RESOLVE) begin
        rcnt <= rcnt + 1'b1;
      end else begin
        rcnt <= '0;
      end
      if (pkt_acc) begin
        cnt <= last_byte ? '0 : cnt_inc;
      end
    end
  end

  // compare-stage payload
  always_ff @(posedge clk) begin
    if (pkt_acc) begin
      cmp_kind   <= kind;
      cmp_pos_ok <= (cnt_x < XW'(TPL_BYTES));
      cmp_pos    <= cnt_x[POS_W-1:0];
      cmp_byte   <= data_byte;
      // lengths top out at 127, so a clipped count compares the same
      cmp_cnt    <= (inc_x > XW'(127)) ? 7'd127 : inc_x[LEN_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_last_starts_eval: assert property (@(posedge clk) disable iff (rst)
    (pkt_acc && last_byte) |=> (state == ST_EVAL && cmp_last))
    else $error("last byte did not start evaluation");

  a_cmp_follows_accept: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> $past(pkt_acc))
    else $error("compare stage without a packet byte");

  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result");

  a_rcnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESOLVE) |-> (rcnt <= EW'(NUM_ENTRIES - 1)))
    else $error("resolve counter overran");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> (cnt == '0))
    else $error("byte count not cleared at packet end");
`endif

endmodule

// File: rtl/core/masked_packet_signature_match.sv
// Top level: controller plus a chain of entry cells carrying the priority token.
// Loads and packet bytes are taken one per cycle while busy is low.
// The result strobe (done) follows the last accepted byte: that byte is compared in EVAL,
// then the lowest-match token hops one cell per cycle through the RESOLVE state.
// The receiver cannot stall.
// Reset zeroes entry lengths and byte count and sets all match bits; templates stay unknown.
`timescale 1ns / 1ps
module masked_packet_signature_match
  import mpsm_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int MAX_LEN     = DEF_MAX_LEN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   cmd,
  input  logic               kind,
  input  logic [ENTRY_W-1:0] entry,
  input  logic [POS_W-1:0]   position,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               care,
  input  logic [LEN_W-1:0]   length,
  input  logic               last_byte,
  output logic               done,
  output logic               matched,
  output logic [ENTRY_W-1:0] entry_index
);

  localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  cell_ctl_t ctl;
  logic          fnd [0:NUM_ENTRIES];
  logic [EW-1:0] idx [0:NUM_ENTRIES];
  logic [EW+ENTRY_W-1:0] idx_ext;

  mpsm_ctrl #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .MAX_LEN    (MAX_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .kind     (kind),
    .entry    (entry),
    .position (position),
    .data_byte(data_byte),
    .care     (care),
    .length   (length),
    .last_byte(last_byte),
    .busy     (busy),
    .done     (done),
    .ctl      (ctl)
  );

  assign fnd[0] = 1'b0;
  assign idx[0] = '0;

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    mpsm_cell #(
      .NUM_ENTRIES(NUM_ENTRIES),
      .CELL_IDX   (g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .fnd_in (fnd[g]),
      .idx_in (idx[g]),
      .fnd_out(fnd[g+1]),
      .idx_out(idx[g+1])
    );
  end

  assign idx_ext     = {{ENTRY_W{1'b0}}, idx[NUM_ENTRIES]};
  assign matched     = fnd[NUM_ENTRIES];
  assign entry_index = matched ? idx_ext[ENTRY_W-1:0] : '0;

endmodule
